// ===== rtl/core/gtht_pkg.sv =====
// Shared types, constants and a helper function for the generation tagged handle table.
// No dependencies.
`timescale 1ns / 1ps
package gtht_pkg;

  localparam int SLOT_BITS  = 12;
  localparam int KIND_BITS  = 4;
  localparam int GEN_BITS   = 16;
  localparam int OBJ_BITS   = 48;
  localparam int TOK_BITS   = 32;
  localparam int CNT_BITS   = SLOT_BITS + 1;
  localparam int MAX_SLOTS  = 1 << SLOT_BITS;
  localparam int KIND_COUNT = 8;
  localparam int CHUNK_DEF  = 1024;

  localparam logic [1:0] OP_MINT_OWNED    = 2'd0;
  localparam logic [1:0] OP_MINT_BORROWED = 2'd1;
  localparam logic [1:0] OP_PEEK          = 2'd2;
  localparam logic [1:0] OP_CLOSE         = 2'd3;

  // One classified command word as it travels from the front to the back.
  typedef struct packed {
    logic [1:0]          op;
    logic [3:0]          kind;
    logic [OBJ_BITS-1:0] obj;
    logic [TOK_BITS-1:0] token;
    logic                bad;
  } cmd_t;

  // One slot of the table.
  typedef struct packed {
    logic [OBJ_BITS-1:0]  obj;
    logic [GEN_BITS-1:0]  gen;
    logic [KIND_BITS-1:0] kind;
    logic                 pv;
    logic [SLOT_BITS-1:0] pidx;
    logic [GEN_BITS-1:0]  pgen;
  } ent_t;

  // Generation after a mint: step once, and once more if that lands on an even value.
  function automatic logic [GEN_BITS-1:0] next_odd_gen(input logic [GEN_BITS-1:0] g);
    logic [GEN_BITS-1:0] g1;
    g1 = g + GEN_BITS'(1);
    if (!g1[0]) g1 = g1 + GEN_BITS'(1);
    return g1;
  endfunction

endpackage

// ===== rtl/core/gtht_front.sv =====
// Front end: classifies an incoming command and flags the failures that the inputs alone decide.
// Depends on gtht_pkg.
`timescale 1ns / 1ps
module gtht_front (
  input  logic [1:0]                   operation,
  input  logic [3:0]                   kind,
  input  logic [gtht_pkg::OBJ_BITS-1:0] object_ref,
  input  logic [gtht_pkg::TOK_BITS-1:0] token,
  output gtht_pkg::cmd_t               cmd
);

  logic mint_bad;
  logic tok_zero;
  logic kind_diff;

  assign mint_bad  = (object_ref == '0) || (kind == 4'd0) ||
                     (32'(kind) >= gtht_pkg::KIND_COUNT);
  assign tok_zero  = (token == '0);
  assign kind_diff = (token[gtht_pkg::SLOT_BITS +: gtht_pkg::KIND_BITS] != kind);

  always_comb begin
    cmd.op    = operation;
    cmd.kind  = kind;
    cmd.obj   = object_ref;
    cmd.token = token;
    unique case (operation)
      gtht_pkg::OP_MINT_OWNED:    cmd.bad = mint_bad;
      gtht_pkg::OP_MINT_BORROWED: cmd.bad = mint_bad || tok_zero;
      default:                    cmd.bad = tok_zero || kind_diff;
    endcase
  end

endmodule

// ===== rtl/core/gtht_queue.sv =====
// Two-entry command queue between the front end and the table engine.
// Depends on gtht_pkg.
`timescale 1ns / 1ps
module gtht_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gtht_pkg::cmd_t push_cmd,
  input  logic           pop,
  output gtht_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  gtht_pkg::cmd_t entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/gtht_back.sv =====
// Table engine: slot memory, free-slot scan, token checks, close and orphan sweeps.
// Depends on gtht_pkg.
`timescale 1ns / 1ps
module gtht_back #(
  parameter int CHUNK = gtht_pkg::CHUNK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  gtht_pkg::cmd_t                q_head,
  output logic                          q_pop,
  output logic                          done,
  output logic [gtht_pkg::TOK_BITS-1:0] result_token,
  output logic [gtht_pkg::OBJ_BITS-1:0] result_object,
  output logic                          success,
  output logic [gtht_pkg::CNT_BITS-1:0] live_count
);

  localparam int SB = gtht_pkg::SLOT_BITS;
  localparam int CB = gtht_pkg::CNT_BITS;
  localparam int GB = gtht_pkg::GEN_BITS;
  localparam int KB = gtht_pkg::KIND_BITS;
  localparam logic [CB-1:0] CAP_MAX = CB'(gtht_pkg::MAX_SLOTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_PCHK    = 4'd2;
  localparam logic [3:0] S_TCHK    = 4'd3;
  localparam logic [3:0] S_SCAN_RD = 4'd4;
  localparam logic [3:0] S_SCAN_EV = 4'd5;
  localparam logic [3:0] S_GROW    = 4'd6;
  localparam logic [3:0] S_SW_RD   = 4'd7;
  localparam logic [3:0] S_SW_EV   = 4'd8;
  localparam logic [3:0] S_SW_PV   = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  gtht_pkg::ent_t mem [gtht_pkg::MAX_SLOTS];
  gtht_pkg::ent_t mem_q;
  gtht_pkg::ent_t rd_val;
  gtht_pkg::ent_t wr_data;
  logic           rd_en;
  logic [SB-1:0]  rd_addr;
  logic           rd_hit;
  logic           wr_en;
  logic [SB-1:0]  wr_addr;

  logic [3:0]     state;
  gtht_pkg::cmd_t cur;
  logic [CB-1:0]  capacity;
  logic [CB-1:0]  scan_start;
  logic [CB-1:0]  live_total;
  logic [CB-1:0]  borrowed_total;
  logic [CB-1:0]  high_water;
  logic [SB-1:0]  probe;
  logic [CB-1:0]  probe_cnt;
  logic           par_valid;
  logic [SB-1:0]  par_idx;
  logic [GB-1:0]  par_gen;
  logic [SB-1:0]  sw_i;
  logic [GB-1:0]  sw_gen;
  logic [GB-1:0]  sw_pgen;
  logic           changed;

  logic [SB-1:0]  tslot;
  logic [KB-1:0]  tkind;
  logic [GB-1:0]  tgen;
  logic           tvalid;
  logic           pok;
  logic           sw_last;
  logic [CB-1:0]  mint_next;
  logic [31:0]    grown;
  logic [CB-1:0]  borrowed_after;

  assign tslot  = cur.token[SB-1:0];
  assign tkind  = cur.token[SB +: KB];
  assign tgen   = cur.token[SB+KB +: GB];
  assign rd_val = rd_hit ? mem_q : '0;
  assign tvalid = (rd_val.obj != '0) && (rd_val.gen == tgen) && (rd_val.kind == tkind);
  assign pok    = (rd_val.obj != '0) && (rd_val.gen == sw_pgen);
  assign sw_last   = (({1'b0, sw_i} + CB'(1)) == high_water);
  assign mint_next = {1'b0, wr_addr} + CB'(1);
  assign grown     = 32'(capacity) + 32'(CHUNK);
  assign borrowed_after = borrowed_total - CB'(rd_val.pv);
  assign q_pop = (state == S_IDLE) && !q_empty;

  // Slot memory with registered read; entries at or above the high-water mark were never
  // written since reset and read as zero through rd_hit.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_hit <= 1'b0;
    else if (rd_en) rd_hit <= ({1'b0, rd_addr} < high_water);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_DISP: begin
        if (!cur.bad && cur.op != gtht_pkg::OP_MINT_OWNED && {1'b0, tslot} < capacity) begin
          rd_en   = 1'b1;
          rd_addr = tslot;
        end
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = probe;
      end
      S_SCAN_EV, S_GROW: begin
        wr_addr      = (state == S_GROW) ? capacity[SB-1:0] : probe;
        wr_en        = (state == S_GROW) ? (capacity != CAP_MAX) : (rd_val.obj == '0);
        wr_data.obj  = cur.obj;
        wr_data.gen  = gtht_pkg::next_odd_gen((state == S_GROW) ? '0 : rd_val.gen);
        wr_data.kind = cur.kind[KB-1:0];
        wr_data.pv   = par_valid;
        wr_data.pidx = par_idx;
        wr_data.pgen = par_gen;
      end
      S_TCHK: begin
        wr_en       = tvalid && (cur.op == gtht_pkg::OP_CLOSE);
        wr_addr     = tslot;
        wr_data.gen = rd_val.gen + GB'(1);
      end
      S_SW_RD: begin
        rd_en   = 1'b1;
        rd_addr = sw_i;
      end
      S_SW_EV: begin
        rd_en   = (rd_val.obj != '0) && rd_val.pv;
        rd_addr = rd_val.pidx;
      end
      S_SW_PV: begin
        wr_en       = !pok;
        wr_addr     = sw_i;
        wr_data.gen = sw_gen + GB'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      capacity       <= '0;
      scan_start     <= '0;
      live_total     <= '0;
      borrowed_total <= '0;
      high_water     <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          result_token  <= '0;
          result_object <= '0;
          success       <= 1'b0;
          par_valid     <= 1'b0;
          par_idx       <= '0;
          par_gen       <= '0;
          if (cur.bad) begin
            state <= S_OUT;
          end else if (cur.op == gtht_pkg::OP_MINT_OWNED) begin
            probe     <= (scan_start == capacity) ? '0 : scan_start[SB-1:0];
            probe_cnt <= '0;
            state     <= (capacity == '0) ? S_GROW : S_SCAN_RD;
          end else if ({1'b0, tslot} >= capacity) begin
            state <= S_OUT;
          end else begin
            state <= (cur.op == gtht_pkg::OP_MINT_BORROWED) ? S_PCHK : S_TCHK;
          end
        end
        S_PCHK: begin
          if (tvalid) begin
            par_valid <= 1'b1;
            par_idx   <= tslot;
            par_gen   <= tgen;
            probe     <= (scan_start == capacity) ? '0 : scan_start[SB-1:0];
            probe_cnt <= '0;
            state     <= S_SCAN_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV, S_GROW: begin
          if (wr_en) begin
            scan_start <= mint_next;
            live_total <= live_total + CB'(1);
            if (par_valid) borrowed_total <= borrowed_total + CB'(1);
            if (mint_next > high_water) high_water <= mint_next;
            if (state == S_GROW) begin
              capacity <= (grown > 32'(gtht_pkg::MAX_SLOTS)) ? CAP_MAX : grown[CB-1:0];
            end
            result_token <= {wr_data.gen, wr_data.kind, wr_addr};
            success      <= 1'b1;
            state        <= S_OUT;
          end else if (state == S_GROW) begin
            state <= S_OUT;
          end else if (probe_cnt == capacity - CB'(1)) begin
            state <= S_GROW;
          end else begin
            probe_cnt <= probe_cnt + CB'(1);
            probe     <= (({1'b0, probe} + CB'(1)) == capacity) ? '0 : probe + SB'(1);
            state     <= S_SCAN_RD;
          end
        end
        S_TCHK: begin
          state <= S_OUT;
          if (tvalid) begin
            result_object <= rd_val.obj;
            success       <= 1'b1;
            if (cur.op == gtht_pkg::OP_CLOSE) begin
              live_total     <= live_total - CB'(1);
              borrowed_total <= borrowed_after;
              if (borrowed_after != '0) begin
                sw_i    <= '0;
                changed <= 1'b0;
                state   <= S_SW_RD;
              end
            end
          end
        end
        S_SW_RD: state <= S_SW_EV;
        S_SW_EV: begin
          if (rd_en) begin
            sw_gen  <= rd_val.gen;
            sw_pgen <= rd_val.pgen;
            state   <= S_SW_PV;
          end else if (!sw_last) begin
            sw_i  <= sw_i + SB'(1);
            state <= S_SW_RD;
          end else if (changed) begin
            sw_i    <= '0;
            changed <= 1'b0;
            state   <= S_SW_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_SW_PV: begin
          if (!pok) begin
            live_total     <= live_total - CB'(1);
            borrowed_total <= borrowed_total - CB'(1);
          end
          if (!sw_last) begin
            changed <= changed || !pok;
            sw_i    <= sw_i + SB'(1);
            state   <= S_SW_RD;
          end else if (changed || !pok) begin
            sw_i    <= '0;
            changed <= 1'b0;
            state   <= S_SW_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done       <= 1'b1;
          live_count <= live_total;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/generation_tagged_handle_table_top.sv =====
// Top level of the generation tagged handle table: front end, command queue and table engine.
// Depends on gtht_pkg, gtht_front, gtht_queue and gtht_back.
`timescale 1ns / 1ps

// A command word is taken at a clock edge where start is high and busy is low; busy rises
// only when the two-entry command queue is full, so commands can be issued while earlier ones
// are still being carried out. Every command produces exactly one result word, in issue order,
// shown for a single cycle with done high; the receiver cannot stall it and must capture it in
// that cycle. Timing is set by the engine's walks over the single-port slot memory. A peek
// passes through dispatch, token check and output. A mint adds a read and an evaluation per
// slot probed in the free-slot scan, which may probe every slot of the current capacity
// before it grows the table. A close adds, when borrowed handles exist, orphan sweeps over
// every slot up to and including the highest slot ever used, with a parent read where a
// parent check is needed, repeated until a sweep frees nothing. After reset the table is
// ready at once: slots above the highest one ever handed out read as free without a clearing
// pass. The result also reports the number of live handles after the command.
module generation_tagged_handle_table_top #(
  parameter int CHUNK = gtht_pkg::CHUNK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [3:0]                    kind,
  input  logic [gtht_pkg::OBJ_BITS-1:0] object_ref,
  input  logic [gtht_pkg::TOK_BITS-1:0] token,
  output logic                          done,
  output logic [gtht_pkg::TOK_BITS-1:0] result_token,
  output logic [gtht_pkg::OBJ_BITS-1:0] result_object,
  output logic                          success,
  output logic [gtht_pkg::CNT_BITS-1:0] live_count
);

  gtht_pkg::cmd_t new_cmd;
  gtht_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           accept;

  // The queue is the only thing that can hold a command off.
  assign busy   = q_full;
  assign accept = start && !q_full;

  gtht_front u_front (
    .operation  (operation),
    .kind       (kind),
    .object_ref (object_ref),
    .token      (token),
    .cmd        (new_cmd)
  );

  gtht_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (new_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  gtht_back #(
    .CHUNK (CHUNK)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (head_cmd),
    .q_pop         (q_pop),
    .done          (done),
    .result_token  (result_token),
    .result_object (result_object),
    .success       (success),
    .live_count    (live_count)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for generation_tagged_handle_table_top: a directed table of commands,
// then random mint, peek and close traffic, each result word checked against a local model.
// Depends on gtht_pkg and the RTL of the handle table.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_CYCLES = 400000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    operation = gtht_pkg::OP_PEEK;
  logic [3:0]                    kind = '0;
  logic [gtht_pkg::OBJ_BITS-1:0] object_ref = '0;
  logic [gtht_pkg::TOK_BITS-1:0] token = '0;
  logic                          done;
  logic [gtht_pkg::TOK_BITS-1:0] result_token;
  logic [gtht_pkg::OBJ_BITS-1:0] result_object;
  logic                          success;
  logic [gtht_pkg::CNT_BITS-1:0] live_count;

  generation_tagged_handle_table_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation), .kind(kind),
    .object_ref(object_ref), .token(token), .done(done), .result_token(result_token),
    .result_object(result_object), .success(success), .live_count(live_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One result word as the table reports it.
  typedef struct packed {
    logic [gtht_pkg::TOK_BITS-1:0] tok;
    logic [gtht_pkg::OBJ_BITS-1:0] obj;
    logic                          ok;
    logic [gtht_pkg::CNT_BITS-1:0] live;
  } reply_t;

  // One row of the directed table. When fixed is set, the typed-in reply is checked as well.
  typedef struct {
    logic [1:0]                    op;
    logic [3:0]                    knd;
    logic [gtht_pkg::OBJ_BITS-1:0] obj;
    logic [gtht_pkg::TOK_BITS-1:0] tok;
    bit                            fixed;
    reply_t                        want;
  } row_t;

  // Shadow copy of the slot table.
  logic [gtht_pkg::OBJ_BITS-1:0]  sh_obj  [gtht_pkg::MAX_SLOTS];
  logic [gtht_pkg::GEN_BITS-1:0]  sh_gen  [gtht_pkg::MAX_SLOTS];
  logic [gtht_pkg::KIND_BITS-1:0] sh_kind [gtht_pkg::MAX_SLOTS];
  bit                             sh_pv   [gtht_pkg::MAX_SLOTS];
  logic [gtht_pkg::SLOT_BITS-1:0] sh_pidx [gtht_pkg::MAX_SLOTS];
  logic [gtht_pkg::GEN_BITS-1:0]  sh_pgen [gtht_pkg::MAX_SLOTS];
  int unsigned sh_cap, sh_scan, sh_live, sh_borrowed;

  reply_t pending_replies[$];
  logic [gtht_pkg::TOK_BITS-1:0] live_tokens[$];  // tokens minted by the bench, some since closed
  int errors = 0;
  int accepted = 0;
  int replies_seen = 0;
  int mints_ok = 0, closes_ok = 0, sweeps_freed = 0;
  int idle_pct = 0;

  function automatic bit slot_live(int unsigned s);
    return sh_obj[s] != 0 && sh_gen[s][0];
  endfunction

  function automatic void release_slot(int unsigned s);
    if (sh_pv[s]) sh_borrowed--;
    sh_obj[s] = '0;
    sh_gen[s] = sh_gen[s] + 1'b1;
    sh_kind[s] = '0;
    sh_pv[s] = 1'b0;
    sh_pidx[s] = '0;
    sh_pgen[s] = '0;
    sh_live--;
  endfunction

  // Frees borrowed handles whose parent died, repeating until a pass frees nothing.
  function automatic void reap_orphans();
    bit changed;
    int unsigned p;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int unsigned i = 0; i < sh_cap; i++) begin
        if (!slot_live(i) || !sh_pv[i]) continue;
        p = 32'(sh_pidx[i]);
        if (p < sh_cap && slot_live(p) && sh_gen[p] == sh_pgen[i]) continue;
        release_slot(i);
        sweeps_freed++;
        changed = 1'b1;
      end
    end
  endfunction

  function automatic logic [gtht_pkg::TOK_BITS-1:0] mint_handle(
      logic [3:0] k, logic [gtht_pkg::OBJ_BITS-1:0] o, bit has_parent, int unsigned pi,
      logic [gtht_pkg::GEN_BITS-1:0] pg);
    int unsigned s, probe;
    bit found;
    s = 0;
    found = 1'b0;
    if (o == 0 || k == 0 || k >= gtht_pkg::KIND_COUNT) return '0;
    for (int unsigned i = 0; i < sh_cap; i++) begin
      probe = (sh_scan + i) % sh_cap;
      if (sh_obj[probe] == 0 && !sh_gen[probe][0]) begin
        s = probe;
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      if (sh_cap >= gtht_pkg::MAX_SLOTS) return '0;
      s = sh_cap;
      sh_cap = (sh_cap + gtht_pkg::CHUNK_DEF > gtht_pkg::MAX_SLOTS) ? gtht_pkg::MAX_SLOTS :
               sh_cap + gtht_pkg::CHUNK_DEF;
    end
    sh_gen[s] = sh_gen[s] + 1'b1;
    if (!sh_gen[s][0]) sh_gen[s] = sh_gen[s] + 1'b1;
    sh_obj[s] = o;
    sh_kind[s] = k;
    sh_pv[s] = has_parent;
    sh_pidx[s] = has_parent ? gtht_pkg::SLOT_BITS'(pi) : '0;
    sh_pgen[s] = has_parent ? pg : '0;
    if (has_parent) sh_borrowed++;
    sh_scan = s + 1;
    sh_live++;
    return {sh_gen[s], k, s[gtht_pkg::SLOT_BITS-1:0]};
  endfunction

  // Applies one command to the shadow table and returns the reply it should produce.
  function automatic reply_t handle_command(logic [1:0] op, logic [3:0] k,
                                            logic [gtht_pkg::OBJ_BITS-1:0] o,
                                            logic [gtht_pkg::TOK_BITS-1:0] t);
    reply_t r;
    int unsigned ts;
    logic [gtht_pkg::GEN_BITS-1:0] tg;
    logic [gtht_pkg::KIND_BITS-1:0] tk;
    r = '{tok: '0, obj: '0, ok: 1'b0, live: '0};
    ts = 32'(t[gtht_pkg::SLOT_BITS-1:0]);
    tk = t[gtht_pkg::SLOT_BITS +: gtht_pkg::KIND_BITS];
    tg = t[gtht_pkg::TOK_BITS-1 -: gtht_pkg::GEN_BITS];
    case (op)
      gtht_pkg::OP_MINT_OWNED: begin
        r.tok = mint_handle(k, o, 1'b0, 0, '0);
      end
      gtht_pkg::OP_MINT_BORROWED: begin
        if (o != 0 && t != 0 && ts < sh_cap && sh_obj[ts] != 0 && sh_gen[ts] == tg &&
            sh_kind[ts] == tk)
          r.tok = mint_handle(k, o, 1'b1, ts, tg);
      end
      default: begin
        if (t != 0 && tk == k && ts < sh_cap && sh_obj[ts] != 0 && sh_gen[ts] == tg &&
            sh_kind[ts] == k) begin
          r.obj = sh_obj[ts];
          r.ok = 1'b1;
          if (op == gtht_pkg::OP_CLOSE) begin
            release_slot(ts);
            if (sh_borrowed > 0) reap_orphans();
          end
        end
      end
    endcase
    if (op == gtht_pkg::OP_MINT_OWNED || op == gtht_pkg::OP_MINT_BORROWED) r.ok = r.tok != 0;
    r.live = sh_live[gtht_pkg::CNT_BITS-1:0];
    return r;
  endfunction

  // Drives one command word and holds it until the table takes it. The predictor runs at
  // the accepting edge so that replies stay in issue order. Start stays high from one
  // command to the next unless the sender takes a gap.
  task automatic issue(logic [1:0] op, logic [3:0] k, logic [gtht_pkg::OBJ_BITS-1:0] o,
                       logic [gtht_pkg::TOK_BITS-1:0] t, bit fixed, reply_t want);
    reply_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    operation <= op;
    kind <= k;
    object_ref <= o;
    token <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = handle_command(op, k, o, t);
    if (fixed && r != want) begin
      $error("directed row: table model disagrees with typed-in reply (op %0d)", op);
      errors++;
    end
    pending_replies.push_back(fixed ? want : r);
    if (r.ok && (op == gtht_pkg::OP_MINT_OWNED || op == gtht_pkg::OP_MINT_BORROWED)) begin
      live_tokens.push_back(r.tok);
      mints_ok++;
    end
    if (r.ok && op == gtht_pkg::OP_CLOSE) closes_ok++;
    accepted++;
  endtask

  // Result checker: done marks a word valid for exactly one cycle.
  always @(posedge clk) begin
    reply_t w;
    if (!rst && done) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $error("result word with no command outstanding");
        errors++;
      end else begin
        w = pending_replies.pop_front();
        if (result_token !== w.tok) begin
          $error("result_token: expected %h, got %h", w.tok, result_token);
          errors++;
        end
        if (result_object !== w.obj) begin
          $error("result_object: expected %h, got %h", w.obj, result_object);
          errors++;
        end
        if (success !== w.ok) begin
          $error("success: expected %b, got %b", w.ok, success);
          errors++;
        end
        if (live_count !== w.live) begin
          $error("live_count: expected %0d, got %0d", w.live, live_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a command nor a result word moves.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Picks a token to aim at: mostly one the bench minted, sometimes damaged or random.
  function automatic logic [gtht_pkg::TOK_BITS-1:0] pick_token();
    logic [gtht_pkg::TOK_BITS-1:0] t;
    int c;
    c = $urandom_range(99);
    if (live_tokens.size() == 0 || c < 8) return $urandom();
    t = live_tokens[$urandom_range(live_tokens.size() - 1)];
    if (c < 16) t[$urandom_range(gtht_pkg::TOK_BITS - 1)] ^= 1'b1;
    return t;
  endfunction

  // One random command, weighted toward well-formed traffic.
  task automatic random_command();
    logic [1:0] op;
    logic [3:0] k;
    logic [gtht_pkg::OBJ_BITS-1:0] o;
    logic [gtht_pkg::TOK_BITS-1:0] t;
    int c;
    reply_t none;
    none = '{tok: '0, obj: '0, ok: 1'b0, live: '0};
    c = $urandom_range(99);
    op = c < 35 ? gtht_pkg::OP_MINT_OWNED : c < 55 ? gtht_pkg::OP_MINT_BORROWED :
         c < 75 ? gtht_pkg::OP_PEEK : gtht_pkg::OP_CLOSE;
    o = gtht_pkg::OBJ_BITS'({$urandom(), $urandom()});
    if ($urandom_range(19) == 0) o = '0;
    t = pick_token();
    k = 4'($urandom_range(1, gtht_pkg::KIND_COUNT - 1));
    if ($urandom_range(15) == 0) k = 4'($urandom_range(15));
    // Peek and close usually name the kind carried in the token.
    if ((op == gtht_pkg::OP_PEEK || op == gtht_pkg::OP_CLOSE) && $urandom_range(9) != 0)
      k = t[gtht_pkg::SLOT_BITS +: 4];
    // Keep the live population small so scans and sweeps stay short.
    if (sh_live > 48 && op == gtht_pkg::OP_MINT_OWNED) op = gtht_pkg::OP_CLOSE;
    issue(op, k, o, t, 1'b0, none);
  endtask

  // Directed rows. Expected replies are typed in where they follow at a glance.
  row_t directed[$];
  function automatic row_t mk(logic [1:0] op, logic [3:0] k, logic [gtht_pkg::OBJ_BITS-1:0] o,
                              logic [gtht_pkg::TOK_BITS-1:0] t, bit fixed,
                              logic [gtht_pkg::TOK_BITS-1:0] wt,
                              logic [gtht_pkg::OBJ_BITS-1:0] wo, logic wok, int wl);
    row_t r;
    r.op = op; r.knd = k; r.obj = o; r.tok = t; r.fixed = fixed;
    r.want = '{tok: wt, obj: wo, ok: wok, live: gtht_pkg::CNT_BITS'(wl)};
    return r;
  endfunction

  localparam logic [gtht_pkg::OBJ_BITS-1:0] OBJ_MAX = '1;

  initial begin
    reply_t none;
    none = '{tok: '0, obj: '0, ok: 1'b0, live: '0};
    for (int i = 0; i < gtht_pkg::MAX_SLOTS; i++) begin
      sh_obj[i] = '0; sh_gen[i] = '0; sh_kind[i] = '0;
      sh_pv[i] = 1'b0; sh_pidx[i] = '0; sh_pgen[i] = '0;
    end
    sh_cap = 0; sh_scan = 0; sh_live = 0; sh_borrowed = 0;

    // Empty table: every lookup fails; bad mints (null object, kind 0, kind too high) fail.
    directed.push_back(mk(gtht_pkg::OP_PEEK, 4'd1, '0, 32'h0001_1000, 1, '0, '0, 0, 0));
    directed.push_back(mk(gtht_pkg::OP_CLOSE, 4'd0, '0, '0, 1, '0, '0, 0, 0));
    directed.push_back(mk(gtht_pkg::OP_MINT_OWNED, 4'd1, '0, '0, 1, '0, '0, 0, 0));
    directed.push_back(mk(gtht_pkg::OP_MINT_OWNED, 4'd0, 48'h1, '0, 1, '0, '0, 0, 0));
    directed.push_back(mk(gtht_pkg::OP_MINT_OWNED, 4'd8, 48'h1, '0, 1, '0, '0, 0, 0));
    directed.push_back(mk(gtht_pkg::OP_MINT_OWNED, 4'd15, OBJ_MAX, 32'hFFFF_FFFF, 1,
                          '0, '0, 0, 0));
    // First mint grows the table and lands in slot 0 with generation 1.
    directed.push_back(mk(gtht_pkg::OP_MINT_OWNED, 4'd1, OBJ_MAX, '0, 1,
                          32'h0001_1000, '0, 1, 1));
    directed.push_back(mk(gtht_pkg::OP_MINT_OWNED, 4'd7, 48'h1, '0, 1,
                          32'h0001_7001, '0, 1, 2));
    directed.push_back(mk(gtht_pkg::OP_PEEK, 4'd1, '0, 32'h0001_1000, 1, '0, OBJ_MAX, 1, 2));
    // Kind input mismatch, wrong generation, slot beyond capacity: all bad tokens.
    directed.push_back(mk(gtht_pkg::OP_PEEK, 4'd2, '0, 32'h0001_1000, 1, '0, '0, 0, 2));
    directed.push_back(mk(gtht_pkg::OP_PEEK, 4'd1, '0, 32'h0003_1000, 1, '0, '0, 0, 2));
    directed.push_back(mk(gtht_pkg::OP_PEEK, 4'd1, '0, 32'h0001_1FFF, 1, '0, '0, 0, 2));
    // Borrowed handles chained off slot 0, then a bad parent.
    directed.push_back(mk(gtht_pkg::OP_MINT_BORROWED, 4'd3, 48'h55, 32'h0001_1000, 1,
                          32'h0001_3002, '0, 1, 3));
    directed.push_back(mk(gtht_pkg::OP_MINT_BORROWED, 4'd4, 48'h66, 32'h0001_3002, 1,
                          32'h0001_4003, '0, 1, 4));
    directed.push_back(mk(gtht_pkg::OP_MINT_BORROWED, 4'd3, 48'h77, 32'h0001_2000, 1,
                          '0, '0, 0, 4));
    directed.push_back(mk(gtht_pkg::OP_MINT_BORROWED, 4'd3, 48'h77, '0, 1, '0, '0, 0, 4));
    // Closing the root cascades through both borrowed generations.
    directed.push_back(mk(gtht_pkg::OP_CLOSE, 4'd1, '0, 32'h0001_1000, 1,
                          '0, OBJ_MAX, 1, 1));
    directed.push_back(mk(gtht_pkg::OP_CLOSE, 4'd1, '0, 32'h0001_1000, 1, '0, '0, 0, 1));
    directed.push_back(mk(gtht_pkg::OP_PEEK, 4'd3, '0, 32'h0001_3002, 1, '0, '0, 0, 1));
    // Reuse continues after the last slot handed out, so the freed slot 0 is not taken yet.
    directed.push_back(mk(gtht_pkg::OP_MINT_OWNED, 4'd2, 48'hABC, '0, 0, '0, '0, 0, 0));
    directed.push_back(mk(gtht_pkg::OP_CLOSE, 4'd7, '0, 32'h0001_7001, 1, '0, 48'h1, 1, 1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      issue(directed[i].op, directed[i].knd, directed[i].obj, directed[i].tok,
            directed[i].fixed, directed[i].want);

    // Random traffic in four sender phases: no gaps, heavy gaps, none again, moderate gaps.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 68 : (ph == 3) ? 35 : 0;
      for (int n = 0; n < 200; n++) random_command();
      // In phase 2 only, stretch the free-slot scan with a burst of mints, then close every held token.
      if (ph == 2) begin
        for (int n = 0; n < 40; n++)
          issue(gtht_pkg::OP_MINT_OWNED, 4'd5,
                gtht_pkg::OBJ_BITS'({$urandom(), $urandom()}) | 48'h1, '0, 1'b0, none);
        while (live_tokens.size() > 0) begin
          issue(gtht_pkg::OP_CLOSE, live_tokens[0][gtht_pkg::SLOT_BITS +: 4], '0,
                live_tokens[0], 1'b0, none);
          void'(live_tokens.pop_front());
        end
      end
    end
    start <= 1'b0;

    while (pending_replies.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d commands, %0d result words; %0d mints, %0d closes, %0d orphans reaped",
             accepted, replies_seen, mints_ok, closes_ok, sweeps_freed);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
